>>> rtl/core/usd_pkg.sv
// ----------------------------------------------------------------------------
// usd_pkg: shared types and constants for the ultrasonic obstacle stop drive
// Register map, command codes, drive patterns and the status record passed
// from the tick engine to the top level.
// ----------------------------------------------------------------------------
package usd_pkg;

   // counter widths
   localparam int LimitWidth = 20;
   localparam int CountWidth = LimitWidth + 1;   // runs one past a 20-bit limit

   // configuration register indexes (byte address = 4 * index)
   localparam logic [2:0] RegThreshold  = 3'd0;
   localparam logic [2:0] RegTrigger    = 3'd1;
   localparam logic [2:0] RegWaitLimit  = 3'd2;
   localparam logic [2:0] RegWidthLimit = 3'd3;
   localparam logic [2:0] RegRest       = 3'd4;

   localparam int AddrWidth = 5;

   // reset values
   localparam logic [8:0]            ThresholdReset  = 9'd40;
   localparam logic [9:0]            TriggerReset    = 10'd10;
   localparam logic [LimitWidth-1:0] WaitLimitReset  = 20'd100000;
   localparam logic [LimitWidth-1:0] WidthLimitReset = 20'd380000;
   localparam logic [LimitWidth-1:0] RestReset       = 20'd100000;

   // command codes
   localparam logic [2:0] CmdStop     = 3'd0;
   localparam logic [2:0] CmdForward  = 3'd1;
   localparam logic [2:0] CmdBackward = 3'd2;
   localparam logic [2:0] CmdLeft     = 3'd3;
   localparam logic [2:0] CmdRight    = 3'd4;

   // ASCII command bytes
   localparam logic [7:0] ByteStop     = 8'h53;   // 'S'
   localparam logic [7:0] ByteForward  = 8'h46;   // 'F'
   localparam logic [7:0] ByteBackward = 8'h42;   // 'B'
   localparam logic [7:0] ByteLeft     = 8'h4C;   // 'L'
   localparam logic [7:0] ByteRight    = 8'h52;   // 'R'

   // H-bridge patterns, bit7 is in1 of the first driver
   localparam logic [7:0] PatStop     = 8'hFF;
   localparam logic [7:0] PatForward  = 8'hA5;
   localparam logic [7:0] PatBackward = 8'h5A;
   localparam logic [7:0] PatLeft     = 8'h55;
   localparam logic [7:0] PatRight    = 8'hAA;

   // obstacle test: width*17 < threshold*1000
   localparam int           ProdWidth = 25;
   localparam logic [24:0]  WidthScale = 25'd17;
   localparam logic [24:0]  ThreshScale = 25'd1000;

   typedef struct packed {
      logic [8:0]            threshold_cm;
      logic [9:0]            trigger_ticks;
      logic [LimitWidth-1:0] echo_wait_limit;
      logic [LimitWidth-1:0] echo_width_limit;
      logic [LimitWidth-1:0] rest_ticks;
   } cfg_type;

   typedef struct packed {
      logic                  trigger_level;
      logic [7:0]            motor_drive;
      logic                  obstacle;
      logic [2:0]            command_code;
      logic                  cycle_done;
      logic [LimitWidth-1:0] echo_width_us;
   } status_type;

   function automatic logic [7:0] cmd_pattern(input logic [2:0] cmd);
      logic [7:0] pat;
      case (cmd)
         CmdStop:     pat = PatStop;
         CmdForward:  pat = PatForward;
         CmdBackward: pat = PatBackward;
         CmdLeft:     pat = PatLeft;
         CmdRight:    pat = PatRight;
         default:     pat = PatStop;
      endcase
      return pat;
   endfunction

endpackage

>>> rtl/core/usd_csr.sv
// ----------------------------------------------------------------------------
// usd_csr: configuration registers
// APB-style write and read of the five timing and threshold registers.
// ----------------------------------------------------------------------------
module usd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [usd_pkg::AddrWidth-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready,
   output usd_pkg::cfg_type              cfg
);

   usd_pkg::cfg_type cfg_ff;
   logic             wr_en;
   logic [2:0]       reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_cm     <= usd_pkg::ThresholdReset;
         cfg_ff.trigger_ticks    <= usd_pkg::TriggerReset;
         cfg_ff.echo_wait_limit  <= usd_pkg::WaitLimitReset;
         cfg_ff.echo_width_limit <= usd_pkg::WidthLimitReset;
         cfg_ff.rest_ticks       <= usd_pkg::RestReset;
      end else if (wr_en) begin
         case (reg_idx)
            usd_pkg::RegThreshold:  cfg_ff.threshold_cm     <= csr_pwdata[8:0];
            usd_pkg::RegTrigger:    cfg_ff.trigger_ticks    <= csr_pwdata[9:0];
            usd_pkg::RegWaitLimit:  cfg_ff.echo_wait_limit  <= csr_pwdata[19:0];
            usd_pkg::RegWidthLimit: cfg_ff.echo_width_limit <= csr_pwdata[19:0];
            usd_pkg::RegRest:       cfg_ff.rest_ticks       <= csr_pwdata[19:0];
            default: ;   // unmapped, ignored
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         usd_pkg::RegThreshold:  csr_prdata = {23'd0, cfg_ff.threshold_cm};
         usd_pkg::RegTrigger:    csr_prdata = {22'd0, cfg_ff.trigger_ticks};
         usd_pkg::RegWaitLimit:  csr_prdata = {12'd0, cfg_ff.echo_wait_limit};
         usd_pkg::RegWidthLimit: csr_prdata = {12'd0, cfg_ff.echo_width_limit};
         usd_pkg::RegRest:       csr_prdata = {12'd0, cfg_ff.rest_ticks};
         default:                csr_prdata = 32'd0;
      endcase
   end

endmodule

>>> rtl/core/usd_step.sv
// ----------------------------------------------------------------------------
// usd_step: per-tick ranging engine
// Phase sequencer, tick counter, command latch, obstacle test and drive
// pattern. State advances once per tick taken from the input register.
// ----------------------------------------------------------------------------
module usd_step (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic                 echo_level,
   input  logic                 rx_valid,
   input  logic [7:0]           rx_byte,
   input  usd_pkg::cfg_type     cfg,
   output usd_pkg::status_type  status
);

   localparam logic [1:0] PhRest    = 2'd0;
   localparam logic [1:0] PhTrigger = 2'd1;
   localparam logic [1:0] PhWait    = 2'd2;
   localparam logic [1:0] PhMeasure = 2'd3;

   localparam int CW = usd_pkg::CountWidth;
   localparam int LW = usd_pkg::LimitWidth;
   localparam int PW = usd_pkg::ProdWidth;

   logic [1:0]    phase_ff,    phase_in;
   logic [CW-1:0] count_ff,    count_in;
   logic [2:0]    command_ff,  command_in;
   logic          obstacle_ff, obstacle_in;
   logic [7:0]    drive_ff,    drive_in;
   logic [LW-1:0] width_ff,    width_in;
   logic          done_ff,     done_in;

   always_comb begin
      logic [2:0]    cmd;
      logic [CW-1:0] cnt_inc;
      logic [CW-1:0] hi_cnt;
      logic          finish;
      logic          fin_valid;
      logic [LW-1:0] fin_width;
      logic          obs;

      // command byte is latched ahead of any drive decision
      cmd = command_ff;
      if (rx_valid) begin
         case (rx_byte)
            usd_pkg::ByteStop:     cmd = usd_pkg::CmdStop;
            usd_pkg::ByteForward:  cmd = usd_pkg::CmdForward;
            usd_pkg::ByteBackward: cmd = usd_pkg::CmdBackward;
            usd_pkg::ByteLeft:     cmd = usd_pkg::CmdLeft;
            usd_pkg::ByteRight:    cmd = usd_pkg::CmdRight;
            default:               cmd = command_ff;
         endcase
      end

      cnt_inc   = count_ff + CW'(1);
      // first high tick in wait counts as one
      hi_cnt    = (phase_ff == PhWait) ? CW'(1) : cnt_inc;
      finish    = 1'b0;
      fin_valid = 1'b0;
      fin_width = '0;
      phase_in  = phase_ff;
      count_in  = count_ff;

      case (phase_ff)
         PhRest: begin
            if (cnt_inc >= {1'b0, cfg.rest_ticks}) begin
               phase_in = PhTrigger;
               count_in = '0;
            end else begin
               count_in = cnt_inc;
            end
         end
         PhTrigger: begin
            if (cnt_inc >= CW'(cfg.trigger_ticks)) begin
               phase_in = PhWait;
               count_in = '0;
            end else begin
               count_in = cnt_inc;
            end
         end
         PhWait, PhMeasure: begin
            if (echo_level) begin
               phase_in = PhMeasure;
               count_in = hi_cnt;
               if (hi_cnt > {1'b0, cfg.echo_width_limit}) begin
                  finish    = 1'b1;   // over-long echo, saturated width
                  fin_width = hi_cnt[CW-1] ? {LW{1'b1}} : hi_cnt[LW-1:0];
               end
            end else if (phase_ff == PhMeasure) begin
               finish    = 1'b1;
               fin_valid = 1'b1;
               fin_width = count_ff[LW-1:0];
            end else begin
               count_in = cnt_inc;
               if (cnt_inc > {1'b0, cfg.echo_wait_limit}) begin
                  finish = 1'b1;      // echo timeout, width zero
               end
            end
         end
         default: begin
            phase_in = PhRest;
            count_in = '0;
         end
      endcase

      obs = fin_valid &&
            ((PW'(fin_width) * usd_pkg::WidthScale) <
             (PW'(cfg.threshold_cm) * usd_pkg::ThreshScale));

      command_in  = cmd;
      obstacle_in = obstacle_ff;
      drive_in    = drive_ff;
      width_in    = width_ff;
      done_in     = finish;
      if (finish) begin
         obstacle_in = obs;
         width_in    = fin_width;
         if (obs && (cmd != usd_pkg::CmdBackward)) begin
            command_in = usd_pkg::CmdStop;
         end
         drive_in = usd_pkg::cmd_pattern(command_in);
         phase_in = PhRest;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PhRest;
         count_ff    <= '0;
         command_ff  <= usd_pkg::CmdStop;
         obstacle_ff <= 1'b0;
         drive_ff    <= usd_pkg::PatStop;
         width_ff    <= '0;
         done_ff     <= 1'b0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         command_ff  <= command_in;
         obstacle_ff <= obstacle_in;
         drive_ff    <= drive_in;
         width_ff    <= width_in;
         done_ff     <= done_in;
      end
   end

   assign status.trigger_level = (phase_ff == PhTrigger);
   assign status.motor_drive   = drive_ff;
   assign status.obstacle      = obstacle_ff;
   assign status.command_code  = command_ff;
   assign status.cycle_done    = done_ff;
   assign status.echo_width_us = width_ff;

endmodule

>>> rtl/core/ultrasonic_obstacle_stop_drive.sv
// A req transfer reaches its rsp through the input register, then the state update.
// Throughput: one tick per cycle while rsp_ready holds; the state registers update once per tick.
// While a result waits, a tick is still taken if the input register is empty;
//   a full input register then holds until the waiting rsp transfer goes out.
// Reset (synchronous, active high): rest phase, counter zero, stop command,
//   drive pattern 0xFF, obstacle and width zero, config to defaults.
// ----------------------------------------------------------------------------
// ultrasonic_obstacle_stop_drive: echo ranging with obstacle stop
// One req transfer is one microsecond tick carrying the echo pin level and an
// optional command byte. Each tick yields one rsp transfer with the trigger
// level, motor pattern, obstacle flag, command and latest echo width.
// ----------------------------------------------------------------------------
module ultrasonic_obstacle_stop_drive (
   input  logic                          clock,
   input  logic                          reset,
   // tick input channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_echo_level,
   input  logic                          req_rx_valid,
   input  logic [7:0]                    req_rx_byte,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_trigger_level,
   output logic [7:0]                    rsp_motor_drive,
   output logic                          rsp_obstacle,
   output logic [2:0]                    rsp_command_code,
   output logic                          rsp_cycle_done,
   output logic [19:0]                   rsp_echo_width_us,
   // configuration port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [usd_pkg::AddrWidth-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   usd_pkg::cfg_type    cfg;
   usd_pkg::status_type status;

   // input register
   logic       in_valid_ff;
   logic       in_echo_ff;
   logic       in_rxv_ff;
   logic [7:0] in_byte_ff;

   // result valid; the payload is the engine's own state registers
   logic       out_valid_ff;

   logic       advance;

   // A tick moves into the engine when the result slot is empty or being drained.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload holds no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_echo_ff <= req_echo_level;
         in_rxv_ff  <= req_rx_valid;
         in_byte_ff <= req_rx_byte;
      end
   end

   usd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // engine state only changes on advance, so it stays stable while rsp stalls
   usd_step u_step (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .echo_level (in_echo_ff),
      .rx_valid   (in_rxv_ff),
      .rx_byte    (in_byte_ff),
      .cfg        (cfg),
      .status     (status)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_trigger_level = status.trigger_level;
   assign rsp_motor_drive   = status.motor_drive;
   assign rsp_obstacle      = status.obstacle;
   assign rsp_command_code  = status.command_code;
   assign rsp_cycle_done    = status.cycle_done;
   assign rsp_echo_width_us = status.echo_width_us;

endmodule

>>> rtl/core/usd_checker.sv
// ----------------------------------------------------------------------------
// usd_checker: port-level checks for the obstacle stop drive
// Watches the result channel for drive and command consistency.
// ----------------------------------------------------------------------------
module usd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_trigger_level,
   input logic [7:0]  rsp_motor_drive,
   input logic        rsp_obstacle,
   input logic [2:0]  rsp_command_code,
   input logic        rsp_cycle_done
);

   // stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before transfer");

   // a finished cycle always returns to rest, never to trigger
   a_done_no_trig: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cycle_done |-> !rsp_trigger_level)
      else $error("trigger high on cycle end");

   // obstacle forces stop unless backing up
   a_obs_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cycle_done && rsp_obstacle |->
         (rsp_command_code == usd_pkg::CmdStop) ||
         (rsp_command_code == usd_pkg::CmdBackward))
      else $error("obstacle did not stop the drive");

   // drive pattern follows the command at cycle end
   a_drive_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cycle_done |->
         rsp_motor_drive == usd_pkg::cmd_pattern(rsp_command_code))
      else $error("motor pattern does not match command");

endmodule

bind ultrasonic_obstacle_stop_drive usd_checker u_usd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_trigger_level (rsp_trigger_level),
   .rsp_motor_drive   (rsp_motor_drive),
   .rsp_obstacle      (rsp_obstacle),
   .rsp_command_code  (rsp_command_code),
   .rsp_cycle_done    (rsp_cycle_done)
);

>>> tb/tb_ultrasonic_obstacle_stop_drive.sv
// ----------------------------------------------------------------------------
// tb_ultrasonic_obstacle_stop_drive: self-checking bench for the ranging core
// Drives microsecond ticks (echo level plus optional command byte) over the
// req channel and checks every rsp transfer against an in-bench model of the
// rest / trigger / wait / measure sequence, the obstacle test and the drive
// pattern. Registers are reprogrammed over APB between phases while idle.
// ----------------------------------------------------------------------------
module tb_ultrasonic_obstacle_stop_drive;

   localparam int CW = usd_pkg::CountWidth;
   localparam int AW = usd_pkg::AddrWidth;

   // ------------------------------------------------------------------------
   // bench-local types
   // ------------------------------------------------------------------------
   typedef enum logic [1:0] {PhRest, PhTrigger, PhWait, PhMeasure} sonar_phase_type;

   // one tick as seen on the req channel
   typedef struct packed {
      logic       echo;
      logic       rxv;
      logic [7:0] rxb;
   } echo_tick_type;

   // single-tick probe with the command we expect latched afterwards
   typedef struct packed {
      logic       echo;
      logic       rxv;
      logic [7:0] rxb;
      logic [2:0] cmd;
   } probe_type;

   // one full measurement: register set, command sent up front, echo shape,
   // byte riding on the falling-edge tick, and whether both sides run flat out
   typedef struct packed {
      usd_pkg::cfg_type cfg;
      logic [7:0]       lead;
      logic [31:0]      gap;
      logic [31:0]      len;
      logic [7:0]       tail;
      logic             calm;
   } scene_type;

   localparam usd_pkg::cfg_type CfgBoundary = '{threshold_cm: 9'd1, trigger_ticks: 10'd1,
      echo_wait_limit: 20'd3, echo_width_limit: 20'd70, rest_ticks: 20'd1};
   localparam usd_pkg::cfg_type CfgZero = '{threshold_cm: 9'd0, trigger_ticks: 10'd0,
      echo_wait_limit: 20'd0, echo_width_limit: 20'd0, rest_ticks: 20'd0};
   localparam usd_pkg::cfg_type CfgWide = '{threshold_cm: 9'd400, trigger_ticks: 10'd2,
      echo_wait_limit: 20'hFFFFF, echo_width_limit: 20'hFFFFF, rest_ticks: 20'd1};

   // Straight after reset the block sits in its 100000-tick rest, so only the
   // command latch moves; everything else reads back at its reset value.
   localparam probe_type Probes [12] = '{
      '{1'b0, 1'b0, 8'h00,                 usd_pkg::CmdStop},
      '{1'b1, 1'b0, usd_pkg::ByteForward,  usd_pkg::CmdStop},      // byte without rx_valid
      '{1'b0, 1'b1, usd_pkg::ByteForward,  usd_pkg::CmdForward},
      '{1'b1, 1'b1, 8'h00,                 usd_pkg::CmdForward},   // unknown bytes ignored
      '{1'b0, 1'b1, 8'hFF,                 usd_pkg::CmdForward},
      '{1'b1, 1'b1, usd_pkg::ByteBackward, usd_pkg::CmdBackward},
      '{1'b0, 1'b1, 8'h66,                 usd_pkg::CmdBackward},  // lower-case f
      '{1'b1, 1'b1, usd_pkg::ByteLeft,     usd_pkg::CmdLeft},
      '{1'b0, 1'b1, usd_pkg::ByteRight,    usd_pkg::CmdRight},
      '{1'b1, 1'b0, usd_pkg::ByteStop,     usd_pkg::CmdRight},
      '{1'b1, 1'b1, 8'hAA,                 usd_pkg::CmdRight},
      '{1'b0, 1'b1, usd_pkg::ByteStop,     usd_pkg::CmdStop}
   };

   // With threshold 1 the obstacle edge lies between widths 58 and 59.
   // The wide set opens every limit, so only a falling echo ends the cycle.
   localparam scene_type Scenes [12] = '{
      '{CfgBoundary, usd_pkg::ByteForward,  32'd2, 32'd58, 8'h00, 1'b0},   // obstacle
      '{CfgBoundary, usd_pkg::ByteForward,  32'd0, 32'd59, 8'h00, 1'b0},   // clear
      '{CfgBoundary, usd_pkg::ByteBackward, 32'd3, 32'd5,  8'h00, 1'b0},   // backward kept
      '{CfgBoundary, usd_pkg::ByteLeft,     32'd4, 32'd1,  8'h00, 1'b0},   // echo timeout
      '{CfgBoundary, usd_pkg::ByteRight,    32'd1, 32'd75, 8'h00, 1'b0},   // over-long echo
      '{CfgBoundary, usd_pkg::ByteForward,  32'd1, 32'd10,
        usd_pkg::ByteLeft, 1'b0},                                           // byte on last tick
      '{CfgBoundary, usd_pkg::ByteForward,  32'd1, 32'd60,
        usd_pkg::ByteRight, 1'b0},
      '{CfgZero,     usd_pkg::ByteForward,  32'd0, 32'd1,  8'h00, 1'b0},   // zero limits
      '{CfgZero,     usd_pkg::ByteStop,     32'd1, 32'd1,  8'h00, 1'b0},
      '{CfgWide,     usd_pkg::ByteForward,  32'd5, 32'd40, 8'h00, 1'b1},
      '{CfgWide,     usd_pkg::ByteBackward, 32'd0, 32'd3,  8'h00, 1'b1},
      '{CfgWide,     usd_pkg::ByteRight,    32'd2, 32'd12,
        usd_pkg::ByteBackward, 1'b1}
   };

   // ------------------------------------------------------------------------
   // DUT hookup
   // ------------------------------------------------------------------------
   logic          clock = 1'b0;
   logic          reset;
   logic          req_valid, req_ready;
   logic          req_echo_level, req_rx_valid;
   logic [7:0]    req_rx_byte;
   logic          rsp_valid, rsp_ready;
   logic          rsp_trigger_level, rsp_obstacle, rsp_cycle_done;
   logic [7:0]    rsp_motor_drive;
   logic [2:0]    rsp_command_code;
   logic [19:0]   rsp_echo_width_us;
   logic          csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [AW-1:0] csr_paddr;
   logic [31:0]   csr_pwdata, csr_prdata;

   ultrasonic_obstacle_stop_drive dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_echo_level    (req_echo_level),
      .req_rx_valid      (req_rx_valid),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_trigger_level (rsp_trigger_level),
      .rsp_motor_drive   (rsp_motor_drive),
      .rsp_obstacle      (rsp_obstacle),
      .rsp_command_code  (rsp_command_code),
      .rsp_cycle_done    (rsp_cycle_done),
      .rsp_echo_width_us (rsp_echo_width_us),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // bench state: model of the block, pending results, error count
   // ------------------------------------------------------------------------
   usd_pkg::cfg_type       sim_cfg;
   sonar_phase_type        sim_phase;
   logic [CW-1:0]          sim_count;
   logic [2:0]             sim_cmd;
   logic                   sim_obstacle;
   logic [7:0]             sim_drive;
   logic [19:0]            sim_width;

   usd_pkg::status_type    pending_status [$];
   int unsigned            mismatches = 0;
   int unsigned            ticks_sent = 0;
   int unsigned            chatter_pct = 0;   // odds of a stray byte per tick
   logic                   steady;            // both sides run without gaps

   // End of a measurement: obstacle flag, width, forced stop, new pattern.
   function automatic void close_cycle(input bit measured, input logic [CW-1:0] w);
      if (measured) begin
         // exact integer form of w * 0.034 / 2 < threshold
         sim_obstacle = ({11'd0, w} * 32'd17) < ({23'd0, sim_cfg.threshold_cm} * 32'd1000);
         sim_width    = w[19:0];
      end else begin
         sim_obstacle = 1'b0;
         sim_width    = (w > 21'hFFFFF) ? 20'hFFFFF : w[19:0];
      end
      if (sim_obstacle && sim_cmd != usd_pkg::CmdBackward) sim_cmd = usd_pkg::CmdStop;
      case (sim_cmd)
         usd_pkg::CmdForward:  sim_drive = usd_pkg::PatForward;
         usd_pkg::CmdBackward: sim_drive = usd_pkg::PatBackward;
         usd_pkg::CmdLeft:     sim_drive = usd_pkg::PatLeft;
         usd_pkg::CmdRight:    sim_drive = usd_pkg::PatRight;
         default:              sim_drive = usd_pkg::PatStop;
      endcase
      sim_phase = PhRest;
      sim_count = '0;
   endfunction

   // One tick through the model; returns the status the block should report.
   function automatic usd_pkg::status_type advance_tick(input echo_tick_type t);
      usd_pkg::status_type s;
      logic                fin;
      fin = 1'b0;
      // a byte is latched first, so it counts on the tick a cycle ends
      if (t.rxv) begin
         case (t.rxb)
            usd_pkg::ByteStop:     sim_cmd = usd_pkg::CmdStop;
            usd_pkg::ByteForward:  sim_cmd = usd_pkg::CmdForward;
            usd_pkg::ByteBackward: sim_cmd = usd_pkg::CmdBackward;
            usd_pkg::ByteLeft:     sim_cmd = usd_pkg::CmdLeft;
            usd_pkg::ByteRight:    sim_cmd = usd_pkg::CmdRight;
            default:               ;
         endcase
      end
      case (sim_phase)
         PhRest: begin
            sim_count++;
            if (sim_count >= sim_cfg.rest_ticks) begin
               sim_phase = PhTrigger;
               sim_count = '0;
            end
         end
         PhTrigger: begin
            sim_count++;
            if (sim_count >= sim_cfg.trigger_ticks) begin
               sim_phase = PhWait;
               sim_count = '0;
            end
         end
         PhWait: begin
            if (t.echo) begin
               // rising tick is already the first high tick
               sim_phase = PhMeasure;
               sim_count = CW'(1);
               if (sim_count > sim_cfg.echo_width_limit) begin
                  close_cycle(1'b0, sim_count);
                  fin = 1'b1;
               end
            end else begin
               sim_count++;
               if (sim_count > sim_cfg.echo_wait_limit) begin
                  close_cycle(1'b0, '0);
                  fin = 1'b1;
               end
            end
         end
         PhMeasure: begin
            if (t.echo) begin
               sim_count++;
               if (sim_count > sim_cfg.echo_width_limit) begin
                  close_cycle(1'b0, sim_count);
                  fin = 1'b1;
               end
            end else begin
               close_cycle(1'b1, sim_count);
               fin = 1'b1;
            end
         end
         default: ;
      endcase
      s.trigger_level = (sim_phase == PhTrigger);
      s.motor_drive   = sim_drive;
      s.obstacle      = sim_obstacle;
      s.command_code  = sim_cmd;
      s.cycle_done    = fin;
      s.echo_width_us = sim_width;
      return s;
   endfunction

   // Mostly real commands, otherwise any byte value.
   function automatic logic [7:0] any_byte();
      case ($urandom_range(0, 9))
         0: return usd_pkg::ByteStop;
         1: return usd_pkg::ByteForward;
         2: return usd_pkg::ByteBackward;
         3: return usd_pkg::ByteLeft;
         4: return usd_pkg::ByteRight;
         default: return 8'($urandom());
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // req side: one transfer per call, random gaps unless steady
   // ------------------------------------------------------------------------
   task automatic send_tick(input echo_tick_type t, input bit typed,
                            input usd_pkg::status_type want, output bit done);
      usd_pkg::status_type p;
      if (!steady) begin
         while ($urandom_range(0, 99) < 27) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid      <= 1'b1;
      req_echo_level <= t.echo;
      req_rx_valid   <= t.rxv;
      req_rx_byte    <= t.rxb;
      do @(posedge clock); while (!req_ready);
      // transfer taken at this edge
      p = advance_tick(t);
      pending_status.push_back(typed ? want : p);
      done = p.cycle_done;
      ticks_sent++;
   endtask

   // Runs ticks until one measurement completes. The echo is shaped from the
   // model's phase: low for 'gap' ticks in wait, then high for 'len' ticks.
   task automatic echo_cycle(input logic [7:0] lead, input int unsigned gap,
                             input int unsigned len, input logic [7:0] tail);
      echo_tick_type t;
      bit            done;
      bit            first;
      done  = 1'b0;
      first = 1'b1;
      while (!done) begin
         t.rxv = ($urandom_range(0, 99) < chatter_pct);
         t.rxb = any_byte();
         case (sim_phase)
            PhWait:    t.echo = (sim_count >= gap);
            PhMeasure: begin
               t.echo = (sim_count < len);
               if (!t.echo && tail != 8'h00) begin
                  t.rxv = 1'b1;
                  t.rxb = tail;
               end
            end
            default:   t.echo = 1'($urandom_range(0, 1));   // ignored outside wait/measure
         endcase
         if (first) begin
            t.rxv = (lead != 8'h00);
            t.rxb = lead;
            first = 1'b0;
         end
         send_tick(t, 1'b0, '0, done);
      end
   endtask

   // Stop sending and let every pending result come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);   // two-stage pipe, plus margin
   endtask

   // APB write: setup then access; psel is left up so writes can run back to back.
   task automatic csr_store(input logic [AW-1:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr[1:0] == 2'b00) begin
         case (addr[AW-1:2])
            usd_pkg::RegThreshold:  sim_cfg.threshold_cm     = data[8:0];
            usd_pkg::RegTrigger:    sim_cfg.trigger_ticks    = data[9:0];
            usd_pkg::RegWaitLimit:  sim_cfg.echo_wait_limit  = data[19:0];
            usd_pkg::RegWidthLimit: sim_cfg.echo_width_limit = data[19:0];
            usd_pkg::RegRest:       sim_cfg.rest_ticks       = data[19:0];
            default:                ;   // unmapped, no effect
         endcase
      end
   endtask

   // Reprogram all five registers once the block is idle; optionally poke an
   // unmapped address too, which must change nothing.
   task automatic retune(input usd_pkg::cfg_type c, input bit stray);
      drain();
      csr_store({usd_pkg::RegThreshold,  2'b00}, 32'(c.threshold_cm));
      csr_store({usd_pkg::RegTrigger,    2'b00}, 32'(c.trigger_ticks));
      csr_store({usd_pkg::RegWaitLimit,  2'b00}, 32'(c.echo_wait_limit));
      csr_store({usd_pkg::RegWidthLimit, 2'b00}, 32'(c.echo_width_limit));
      csr_store({usd_pkg::RegRest,       2'b00}, 32'(c.rest_ticks));
      if (stray) csr_store({3'($urandom_range(5, 7)), 2'b00}, $urandom());
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // rsp side: random back-pressure and the checker
   // ------------------------------------------------------------------------
   always @(posedge clock) rsp_ready <= steady || ($urandom_range(0, 99) >= 27);

   always @(posedge clock) begin : rsp_check
      usd_pkg::status_type got;
      usd_pkg::status_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_trigger_level, rsp_motor_drive, rsp_obstacle, rsp_command_code,
                rsp_cycle_done, rsp_echo_width_us};
         if (pending_status.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result with nothing pending: trig=%b drive=%h obst=%b cmd=%0d",
                        $time, got.trigger_level, got.motor_drive, got.obstacle,
                        got.command_code);
         end else begin
            want = pending_status.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: status mismatch", $time);
                  $display("   exp trig=%b drive=%h obst=%b cmd=%0d done=%b width=%0d",
                           want.trigger_level, want.motor_drive, want.obstacle,
                           want.command_code, want.cycle_done, want.echo_width_us);
                  $display("   got trig=%b drive=%h obst=%b cmd=%0d done=%b width=%0d",
                           got.trigger_level, got.motor_drive, got.obstacle,
                           got.command_code, got.cycle_done, got.echo_width_us);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin
      usd_pkg::cfg_type    c;
      echo_tick_type       t;
      usd_pkg::status_type want;
      bit                  done;
      int unsigned         rand_base;
      int unsigned         cyc;
      int unsigned         gap;
      int unsigned         len;

      // every input known from time zero
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_echo_level = 1'b0;
      req_rx_valid   = 1'b0;
      req_rx_byte    = 8'h00;
      rsp_ready      = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      steady         = 1'b0;

      // model starts from the reset state
      sim_cfg      = '{usd_pkg::ThresholdReset, usd_pkg::TriggerReset,
                       usd_pkg::WaitLimitReset, usd_pkg::WidthLimitReset,
                       usd_pkg::RestReset};
      sim_phase    = PhRest;
      sim_count    = '0;
      sim_cmd      = usd_pkg::CmdStop;
      sim_obstacle = 1'b0;
      sim_drive    = usd_pkg::PatStop;
      sim_width    = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // --- single ticks straight after reset, expected values typed in ---
      foreach (Probes[i]) begin
         t    = '{Probes[i].echo, Probes[i].rxv, Probes[i].rxb};
         want = '{1'b0, usd_pkg::PatStop, 1'b0, Probes[i].cmd, 1'b0, 20'd0};
         send_tick(t, 1'b1, want, done);
      end

      // --- whole measurements around the special cases, model-checked ---
      foreach (Scenes[i]) begin
         if (Scenes[i].cfg != sim_cfg) retune(Scenes[i].cfg, 1'b0);
         steady <= Scenes[i].calm;
         echo_cycle(Scenes[i].lead, Scenes[i].gap, Scenes[i].len, Scenes[i].tail);
      end

      // --- random measurements: mostly well-formed echoes, some noise ---
      chatter_pct = 8;
      rand_base   = ticks_sent;
      cyc         = 0;
      while (ticks_sent - rand_base < 470) begin
         if (cyc % 4 == 0) begin
            case ($urandom_range(0, 5))
               0:       c.threshold_cm = 9'd0;
               1:       c.threshold_cm = 9'd511;
               2:       c.threshold_cm = 9'd400;
               default: c.threshold_cm = 9'($urandom_range(1, 3));
            endcase
            c.trigger_ticks    = ($urandom_range(0, 7) == 0) ? '0 : 10'($urandom_range(1, 4));
            c.echo_wait_limit  = ($urandom_range(0, 7) == 0) ? '0 : 20'($urandom_range(1, 12));
            c.echo_width_limit = ($urandom_range(0, 7) == 0) ? '0 : 20'($urandom_range(1, 130));
            c.rest_ticks       = ($urandom_range(0, 7) == 0) ? '0 : 20'($urandom_range(1, 6));
            retune(c, $urandom_range(0, 2) == 0);
         end
         // a long stretch with neither side pausing
         steady <= (cyc >= 3 && cyc < 7);
         if ($urandom_range(0, 5) == 0) begin
            // noise ticks that ignore the phase entirely
            repeat ($urandom_range(1, 4)) begin
               t = echo_tick_type'(10'($urandom()));
               send_tick(t, 1'b0, '0, done);
            end
         end
         gap = $urandom_range(0, sim_cfg.echo_wait_limit + 2);
         len = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 12)
                                           : $urandom_range(1, sim_cfg.echo_width_limit + 4);
         echo_cycle(($urandom_range(0, 1) == 0) ? any_byte() : 8'h00, gap, len,
                    ($urandom_range(0, 3) == 0) ? any_byte() : 8'h00);
         cyc++;
      end

      drain();
      if (mismatches == 0)
         $display("** ultrasonic_obstacle_stop_drive: PASSED **");
      else
         $display("** ultrasonic_obstacle_stop_drive: FAILED **");
      $finish;
   end

   // hard stop far beyond the slowest legal run
   initial begin
      #1_000_000;
      $display("** ultrasonic_obstacle_stop_drive: FAILED **");
      $finish;
   end

endmodule
